FILE: sv/icalc_pkg.sv
// Shared constants, operation codes and the pipeline stage record for the
// integer calculator ALU. No dependencies.
package icalc_pkg;

    localparam int OPERAND_WIDTH      = 32;
    localparam int ROOT_FRACTION_BITS = 16;
    localparam int RESULT_WIDTH       = 64;
    localparam int FUNC_WIDTH         = 3;

    // Root digit pairs: sixteen integer pairs plus the fraction pairs
    localparam int ROOT_PAIRS   = 16 + ROOT_FRACTION_BITS;
    localparam int RAD_WIDTH    = 2 * (ROOT_PAIRS - ROOT_FRACTION_BITS);
    localparam int SQ_REM_WIDTH = ROOT_PAIRS + 3;

    // One divide bit and one root pair per iteration stage
    localparam int ITER_STAGES = (OPERAND_WIDTH > ROOT_PAIRS) ? OPERAND_WIDTH : ROOT_PAIRS;

    localparam logic [FUNC_WIDTH-1:0] FUNC_ADD    = 3'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_SUB    = 3'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_MUL    = 3'd2;
    localparam logic [FUNC_WIDTH-1:0] FUNC_DIV    = 3'd3;
    localparam logic [FUNC_WIDTH-1:0] FUNC_SQUARE = 3'd4;
    localparam logic [FUNC_WIDTH-1:0] FUNC_SQRT   = 3'd5;

    typedef struct packed {
        logic                           valid;
        logic [FUNC_WIDTH-1:0]          func;
        logic signed [RESULT_WIDTH-1:0] early;
        logic                           q_neg;
        logic                           dz;
        logic                           inv;
        logic [OPERAND_WIDTH:0]         div_rem;
        logic [OPERAND_WIDTH-1:0]       div_dvd;
        logic [OPERAND_WIDTH-1:0]       div_dsr;
        logic [RAD_WIDTH-1:0]           sq_rad;
        logic [SQ_REM_WIDTH-1:0]        sq_rem;
        logic [ROOT_PAIRS-1:0]          sq_root;
    } stage_t;

endpackage

FILE: sv/icalc_if.sv
// Request and response channel interfaces of the calculator ALU.
// Depends on icalc_pkg for field widths.
interface icalc_req_if;
    logic                                         valid;
    logic                                         ready;
    logic [icalc_pkg::FUNC_WIDTH-1:0]             func;
    logic signed [icalc_pkg::OPERAND_WIDTH-1:0]   operand_a;
    logic signed [icalc_pkg::OPERAND_WIDTH-1:0]   operand_b;

    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface icalc_rsp_if;
    logic                                         valid;
    logic                                         ready;
    logic signed [icalc_pkg::RESULT_WIDTH-1:0]    result;
    logic                                         div_by_zero;
    logic                                         root_invalid;

    modport source (output valid, result, div_by_zero, root_invalid, input ready);
    modport sink   (input valid, result, div_by_zero, root_invalid, output ready);
endinterface

FILE: sv/icalc_prep.sv
// Entry stage: operand decode, magnitudes, add/sub/multiply and iteration seeds.
// Depends on icalc_pkg.
module icalc_prep (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       advance,
    input  logic                                       in_valid,
    input  logic [icalc_pkg::FUNC_WIDTH-1:0]           func,
    input  logic signed [icalc_pkg::OPERAND_WIDTH-1:0] operand_a,
    input  logic signed [icalc_pkg::OPERAND_WIDTH-1:0] operand_b,
    output icalc_pkg::stage_t                          stage_out
);

    logic signed [icalc_pkg::OPERAND_WIDTH-1:0]   mul_b;
    logic signed [2*icalc_pkg::OPERAND_WIDTH-1:0] prod;
    logic [icalc_pkg::OPERAND_WIDTH-1:0]          mag_a;
    logic [icalc_pkg::OPERAND_WIDTH-1:0]          mag_b;
    icalc_pkg::stage_t                            stage_next;
    icalc_pkg::stage_t                            stage_reg;
    logic                                         valid_reg;

    // Share one multiplier between multiply and square
    assign mul_b = (func == icalc_pkg::FUNC_SQUARE) ? operand_a : operand_b;
    assign prod  = operand_a * mul_b;
    assign mag_a = operand_a[icalc_pkg::OPERAND_WIDTH-1] ? -operand_a : operand_a;
    assign mag_b = operand_b[icalc_pkg::OPERAND_WIDTH-1] ? -operand_b : operand_b;

    // Build the seed record
    always_comb
    begin
        stage_next       = '0;
        stage_next.valid = in_valid;
        stage_next.func  = func;
        case (func)
            icalc_pkg::FUNC_ADD:
                stage_next.early = icalc_pkg::RESULT_WIDTH'(operand_a)
                                 + icalc_pkg::RESULT_WIDTH'(operand_b);
            icalc_pkg::FUNC_SUB:
                stage_next.early = icalc_pkg::RESULT_WIDTH'(operand_a)
                                 - icalc_pkg::RESULT_WIDTH'(operand_b);
            icalc_pkg::FUNC_MUL,
            icalc_pkg::FUNC_SQUARE:
                stage_next.early = icalc_pkg::RESULT_WIDTH'(prod);
            default:
                stage_next.early = '0;
        endcase
        stage_next.q_neg   = operand_a[icalc_pkg::OPERAND_WIDTH-1]
                           ^ operand_b[icalc_pkg::OPERAND_WIDTH-1];
        stage_next.dz      = (func == icalc_pkg::FUNC_DIV) && (operand_b == '0);
        stage_next.inv     = (func == icalc_pkg::FUNC_SQRT)
                           && operand_a[icalc_pkg::OPERAND_WIDTH-1];
        stage_next.div_dvd = mag_a;
        stage_next.div_dsr = mag_b;
        stage_next.sq_rad  = icalc_pkg::RAD_WIDTH'(mag_a);
    end

    // Hold on stall; valid is the only control bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    // Merge the reset valid bit into the record
    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = valid_reg;
    end

endmodule

FILE: sv/icalc_iter_stage.sv
// One iteration stage: a restoring divide step and a root digit step side by side.
// Depends on icalc_pkg.
module icalc_iter_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              div_en,
    input  logic              sq_en,
    input  icalc_pkg::stage_t stage_in,
    output icalc_pkg::stage_t stage_out
);

    logic [icalc_pkg::OPERAND_WIDTH:0]  div_sh;
    logic                               div_bit;
    logic [icalc_pkg::SQ_REM_WIDTH-1:0] sq_sh;
    logic [icalc_pkg::SQ_REM_WIDTH-1:0] sq_trial;
    logic                               sq_bit;
    icalc_pkg::stage_t                  stage_next;
    icalc_pkg::stage_t                  stage_reg;
    logic                               valid_reg;

    // Shift in the next dividend bit and the next radicand pair
    assign div_sh   = {stage_in.div_rem[icalc_pkg::OPERAND_WIDTH-1:0],
                       stage_in.div_dvd[icalc_pkg::OPERAND_WIDTH-1]};
    assign div_bit  = div_sh >= {1'b0, stage_in.div_dsr};
    assign sq_sh    = {stage_in.sq_rem[icalc_pkg::SQ_REM_WIDTH-3:0],
                       stage_in.sq_rad[icalc_pkg::RAD_WIDTH-1 -: 2]};
    assign sq_trial = icalc_pkg::SQ_REM_WIDTH'({stage_in.sq_root, 2'b01});
    assign sq_bit   = sq_sh >= sq_trial;

    always_comb
    begin
        stage_next = stage_in;
        if (div_en)
        begin
            stage_next.div_rem = div_bit ? (div_sh - {1'b0, stage_in.div_dsr}) : div_sh;
            stage_next.div_dvd = {stage_in.div_dvd[icalc_pkg::OPERAND_WIDTH-2:0], div_bit};
        end
        if (sq_en)
        begin
            stage_next.sq_rem  = sq_bit ? (sq_sh - sq_trial) : sq_sh;
            stage_next.sq_rad  = {stage_in.sq_rad[icalc_pkg::RAD_WIDTH-3:0], 2'b00};
            stage_next.sq_root = {stage_in.sq_root[icalc_pkg::ROOT_PAIRS-2:0], sq_bit};
        end
    end

    // Advance with the pipeline, hold on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    // Merge the reset valid bit into the record
    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = valid_reg;
    end

endmodule

FILE: sv/icalc_finish.sv
// Output stage: quotient sign fix, result select and the response register.
// Depends on icalc_pkg.
module icalc_finish (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      advance,
    input  icalc_pkg::stage_t                         stage_in,
    output logic                                      out_valid,
    output logic signed [icalc_pkg::RESULT_WIDTH-1:0] result,
    output logic                                      div_by_zero,
    output logic                                      root_invalid
);

    logic signed [icalc_pkg::RESULT_WIDTH-1:0] quot;
    logic signed [icalc_pkg::RESULT_WIDTH-1:0] result_next;
    logic signed [icalc_pkg::RESULT_WIDTH-1:0] result_reg;
    logic                                      valid_reg;
    logic                                      dz_reg;
    logic                                      inv_reg;

    assign quot = icalc_pkg::RESULT_WIDTH'(stage_in.div_dvd);

    // Select the result for the operation
    always_comb
    begin
        case (stage_in.func)
            icalc_pkg::FUNC_DIV:
                result_next = stage_in.dz ? '0 : (stage_in.q_neg ? -quot : quot);
            icalc_pkg::FUNC_SQRT:
                result_next = stage_in.inv ? '0
                            : icalc_pkg::RESULT_WIDTH'(stage_in.sq_root);
            default:
                result_next = stage_in.early;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
            dz_reg     <= stage_in.dz;
            inv_reg    <= stage_in.inv;
        end
    end

    assign out_valid    = valid_reg;
    assign result       = result_reg;
    assign div_by_zero  = dz_reg;
    assign root_invalid = inv_reg;

endmodule

FILE: sv/integer_calculator_alu.sv
// Top level of the integer calculator ALU: entry stage, iteration stages, output stage.
// Depends on icalc_pkg, icalc_if, icalc_prep, icalc_iter_stage and icalc_finish.
//
// Usage:
//   req carries func, operand_a and operand_b; rsp returns result, div_by_zero
//   and root_invalid, one response per request, in request order.
//   A transaction completes on a rising edge with valid and ready both high.
//   Requests pass through one entry stage, one stage per divide bit / root
//   pair and one output register. The iteration count is set by the wider
//   of the divide and the root loops.
//   Throughput is one transaction per cycle unless rsp stalls; every op takes the same path.
//   When rsp is stalled with a result waiting, the whole pipeline holds and req
//   ready drops; while the output register is empty, req is taken regardless.
//   Reset clears the valid bits only; the pipeline is empty after reset.
module integer_calculator_alu (
    input  logic        clk,
    input  logic        rst_n,
    icalc_req_if.sink   req,
    icalc_rsp_if.source rsp
);

    logic              advance;
    icalc_pkg::stage_t stage_q [0:icalc_pkg::ITER_STAGES];

    // Move the whole pipe unless a result is waiting on a stalled receiver
    assign advance   = !rsp.valid || rsp.ready;
    assign req.ready = advance;

    icalc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (req.valid),
        .func      (req.func),
        .operand_a (req.operand_a),
        .operand_b (req.operand_b),
        .stage_out (stage_q[0])
    );

    // Divide steps fill the last stages, root steps likewise
    for (genvar k = 0; k < icalc_pkg::ITER_STAGES; k++)
    begin : g_iter
        icalc_iter_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .div_en    (1'(k >= icalc_pkg::ITER_STAGES - icalc_pkg::OPERAND_WIDTH)),
            .sq_en     (1'(k >= icalc_pkg::ITER_STAGES - icalc_pkg::ROOT_PAIRS)),
            .stage_in  (stage_q[k]),
            .stage_out (stage_q[k+1])
        );
    end

    icalc_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .stage_in     (stage_q[icalc_pkg::ITER_STAGES]),
        .out_valid    (rsp.valid),
        .result       (rsp.result),
        .div_by_zero  (rsp.div_by_zero),
        .root_invalid (rsp.root_invalid)
    );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the integer calculator ALU: random and directed
// requests, predicted results compared in order. Depends on icalc_pkg, icalc_if.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [icalc_pkg::FUNC_WIDTH-1:0]           func;
        logic signed [icalc_pkg::OPERAND_WIDTH-1:0] a;
        logic signed [icalc_pkg::OPERAND_WIDTH-1:0] b;
    } request_t;

    typedef struct packed {
        logic signed [icalc_pkg::RESULT_WIDTH-1:0] result;
        logic                                      dz;
        logic                                      inv;
    } answer_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    icalc_req_if req ();
    icalc_rsp_if rsp ();

    integer_calculator_alu dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    bit       stimulus_done;
    int       error_count;
    int       send_gap;
    int       recv_gap;
    int       idle_cycles;

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // floor(sqrt(a) * 2^ROOT_FRACTION_BITS) by bisection on 128-bit squares
    function automatic logic [63:0] fixed_sqrt(input logic [63:0] a);
        logic [127:0] target;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        target = {64'd0, a} << (2 * icalc_pkg::ROOT_FRACTION_BITS);
        lo = 64'd0;
        hi = 64'd1 << 40;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if ({64'd0, mid} * {64'd0, mid} <= target)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic answer_t compute_answer(input request_t r);
        answer_t ans;
        logic signed [icalc_pkg::RESULT_WIDTH-1:0] a;
        logic signed [icalc_pkg::RESULT_WIDTH-1:0] b;
        ans = '0;
        a = icalc_pkg::RESULT_WIDTH'(r.a);
        b = icalc_pkg::RESULT_WIDTH'(r.b);
        case (r.func)
            icalc_pkg::FUNC_ADD:    ans.result = a + b;
            icalc_pkg::FUNC_SUB:    ans.result = a - b;
            icalc_pkg::FUNC_MUL:    ans.result = a * b;
            icalc_pkg::FUNC_DIV:
                if (b == 0)
                    ans.dz = 1'b1;
                else
                    ans.result = a / b;
            icalc_pkg::FUNC_SQUARE: ans.result = a * a;
            icalc_pkg::FUNC_SQRT:
                if (a < 0)
                    ans.inv = 1'b1;
                else
                    ans.result = fixed_sqrt(a);
            default:                ans.result = '0;
        endcase
        return ans;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            3: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(input logic [2:0] f, input logic [31:0] a,
                                 input logic [31:0] b);
        request_t r;
        r.func = f;
        r.a = a;
        r.b = b;
        pending_requests.push_back(r);
    endtask

    // Stimulus
    initial
    begin
        logic [2:0] f;
        stimulus_done = 1'b0;
        queue_request(icalc_pkg::FUNC_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_request(icalc_pkg::FUNC_ADD, 32'h8000_0000, 32'h8000_0000);
        queue_request(icalc_pkg::FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff);
        queue_request(icalc_pkg::FUNC_SUB, 32'h7fff_ffff, 32'h8000_0000);
        queue_request(icalc_pkg::FUNC_MUL, 32'h8000_0000, 32'h8000_0000);
        queue_request(icalc_pkg::FUNC_MUL, 32'h7fff_ffff, 32'h8000_0000);
        queue_request(icalc_pkg::FUNC_DIV, 32'd100, 32'd0);
        queue_request(icalc_pkg::FUNC_DIV, 32'h8000_0000, 32'hffff_ffff);
        queue_request(icalc_pkg::FUNC_DIV, -32'sd7, 32'd2);
        queue_request(icalc_pkg::FUNC_DIV, 32'd7, -32'sd2);
        queue_request(icalc_pkg::FUNC_DIV, 32'd0, 32'h8000_0000);
        queue_request(icalc_pkg::FUNC_SQUARE, 32'h8000_0000, 32'd5);
        queue_request(icalc_pkg::FUNC_SQUARE, 32'h7fff_ffff, 32'd0);
        queue_request(icalc_pkg::FUNC_SQRT, 32'd0, 32'd0);
        queue_request(icalc_pkg::FUNC_SQRT, 32'd1, 32'hffff_ffff);
        queue_request(icalc_pkg::FUNC_SQRT, 32'd2, 32'd0);
        queue_request(icalc_pkg::FUNC_SQRT, 32'h7fff_ffff, 32'd0);
        queue_request(icalc_pkg::FUNC_SQRT, 32'hffff_ffff, 32'd0);
        queue_request(icalc_pkg::FUNC_SQRT, 32'h8000_0000, 32'd0);
        queue_request(3'd6, 32'd5, 32'd6);
        queue_request(3'd7, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 450; i++)
        begin
            f = 3'($urandom_range(0, 7));
            // Keep unused codes rare; make zero divisors show up often enough
            if (f > icalc_pkg::FUNC_SQRT && $urandom_range(0, 3) != 0)
                f = 3'($urandom_range(0, 5));
            queue_request(f, random_operand(),
                          (f == icalc_pkg::FUNC_DIV && $urandom_range(0, 9) == 0)
                              ? 32'd0 : random_operand());
        end
        stimulus_done = 1'b1;
    end

    // Driver: hold each transaction until accepted, then wait a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.func      <= '0;
            req.operand_a <= '0;
            req.operand_b <= '0;
            send_gap      <= 0;
        end
        else if (req.valid && !req.ready)
        begin
            // hold
        end
        else if (send_gap > 0)
        begin
            req.valid <= 1'b0;
            send_gap  <= send_gap - 1;
        end
        else if (pending_requests.size() > 0)
        begin
            request_t r;
            r = pending_requests.pop_front();
            expected_answers.push_back(compute_answer(r));
            req.valid     <= 1'b1;
            req.func      <= r.func;
            req.operand_a <= r.a;
            req.operand_b <= r.b;
            send_gap      <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 0;
        end
        else
            req.valid <= 1'b0;
    end

    // Monitor: check each accepted transaction, then stall ready at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                int gap;
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result %0d", $time, rsp.result);
                    error_count++;
                end
                else
                begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (e.result !== rsp.result || e.dz !== rsp.div_by_zero
                        || e.inv !== rsp.root_invalid)
                    begin
                        $display("%0t: expected %0d dz %0b inv %0b, actual %0d dz %0b inv %0b",
                                 $time, e.result, e.dz, e.inv, rsp.result,
                                 rsp.div_by_zero, rsp.root_invalid);
                        error_count++;
                    end
                end
                gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 7)) : 0;
                recv_gap  <= gap;
                rsp.ready <= (gap == 0);
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                rsp.ready <= (recv_gap == 1);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Reset, watchdog and end of run
    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stimulus_done && pending_requests.size() == 0
                 && expected_answers.size() == 0 && !req.valid)
               && idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     expected_answers.size());
            $display("Test completed with failures");
        end
        else
        begin
            repeat (icalc_pkg::ITER_STAGES + 10) @(posedge clk);
            if (error_count == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: files.f
sv/icalc_pkg.sv
sv/icalc_if.sv
sv/icalc_prep.sv
sv/icalc_iter_stage.sv
sv/icalc_finish.sv
sv/integer_calculator_alu.sv
test/testbench.sv
